// ===== hdl/cmrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, codes and defaults of the conservative mark range table
// no dependencies
package cmrt_pkg;

    localparam int MaxBlocksDef     = 32;
    localparam int SlotsPerBlockDef = 64;
    localparam int DivSteps         = 32;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_MARK  = 2'd2,
        MODE_SWEEP = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_REJECT     = 3'd1,
        ST_NO_BLOCK   = 3'd2,
        ST_MISALIGNED = 3'd3,
        ST_SLOT_RANGE = 3'd4,
        ST_BAD_INDEX  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_DIV,
        S_INSERT,
        S_SEARCH,
        S_MARK_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
        logic [31:0] length;
        logic [15:0] stride_bytes;
        logic [4:0]  entry_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  entry_total;
        logic        block_dead;
        logic [63:0] live_mask;
        logic [63:0] entry_base;
        logic [15:0] entry_stride;
        logic [6:0]  entry_slots;
    } t_rsp;

    // one table entry as held by a cell
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] end_addr;
        logic [15:0] stride;
        logic [6:0]  slots;
        logic [63:0] marks;
        logic        live;
    } t_entry;

    // per-cell update controls
    typedef struct packed {
        logic       shift;
        logic       load_new;
        logic       set_live;
        logic       set_mark;
        logic [5:0] mark_bit;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hdl/conservative_mark_range_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Conservative mark range table: a row of entry cells kept sorted by base,
// with insert, binary-search mark and sweep report. One request at a time:
// clear and sweep go straight to the result; an add runs the slot count
// division, then insert and result, or skips the division when the stride
// is zero, the length is zero or the table is full; a mark runs the search
// probes, then the offset division when the entry is slotted, then the result.
// The shared divider works one bit per cycle; a stalled response
// holds the block until it is taken. No clearing pass is needed after reset.
module conservative_mark_range_table_top #(
    parameter int MAX_BLOCKS      = cmrt_pkg::MaxBlocksDef,
    parameter int SLOTS_PER_BLOCK = cmrt_pkg::SlotsPerBlockDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire cmrt_pkg::t_req i_in_req,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output cmrt_pkg::t_rsp      o_out_rsp
);
    localparam int FW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = $clog2(MAX_BLOCKS);

    cmrt_pkg::t_state  r_state, n_state;
    cmrt_pkg::t_req    r_req;
    cmrt_pkg::t_rsp    r_res, n_res;
    cmrt_pkg::t_rsp    r_out;
    cmrt_pkg::t_rsp    w_out;
    logic              r_out_valid;
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_lo, n_lo, r_hi, n_hi;
    logic [IW-1:0]     r_mid, n_mid;
    logic [6:0]        r_slots, n_slots;
    logic              w_out_free;
    logic              w_div_start;
    logic [31:0]       w_div_dvd;
    logic              w_div_done;
    logic [31:0]       w_div_q;
    logic [15:0]       w_div_r;
    logic [FW-1:0]     w_mid;
    cmrt_pkg::t_entry  w_sel;
    cmrt_pkg::t_entry  w_new;
    logic [63:0]       w_off;
    logic [64:0]       w_end;
    logic [IW-1:0]     w_idx;
    logic              w_mark_hit;
    logic [5:0]        w_mark_bit;

    cmrt_pkg::t_entry    w_entry [MAX_BLOCKS];
    cmrt_pkg::t_cell_ctl w_ctl   [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] w_le;
    logic [MAX_BLOCKS-1:0] w_le_raw;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != cmrt_pkg::S_IDLE);
    assign w_end      = {1'b0, r_req.address} + {33'd0, r_req.length};
    assign w_mid      = FW'(r_lo + ((r_hi - r_lo) >> 1));
    assign w_sel      = w_entry[w_mid[IW-1:0]];
    assign w_off      = r_req.address - w_sel.base;
    assign w_idx      = IW'(r_req.entry_index);

    // new entry built from the held add request
    always_comb begin
        w_new          = '0;
        w_new.base     = r_req.address;
        w_new.end_addr = w_end[63:0];
        w_new.stride   = r_req.stride_bytes;
        w_new.slots    = r_slots;
    end

    // shared divider: slot count on add, offset on mark
    assign w_div_dvd = (r_state == cmrt_pkg::S_IDLE) ? i_in_req.length : w_off[31:0];
    assign w_div_start = ((r_state == cmrt_pkg::S_IDLE) && (n_state == cmrt_pkg::S_ADD_DIV))
                         || ((r_state == cmrt_pkg::S_SEARCH)
                             && (n_state == cmrt_pkg::S_MARK_DIV));

    cmrt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  ((r_state == cmrt_pkg::S_IDLE) ? i_in_req.stride_bytes : w_sel.stride),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    assign w_mark_hit = (r_state == cmrt_pkg::S_MARK_DIV) && w_div_done
                        && (w_div_r == '0)
                        && (w_div_q < {25'd0, w_entry[r_mid].slots});
    assign w_mark_bit = w_div_q[5:0];

    // row of cells, each handed its left neighbor
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        logic prev_le;
        assign w_le[g]  = w_le_raw[g] && (FW'(g) < r_fill);
        assign prev_le  = (g == 0) ? 1'b1 : w_le[(g == 0) ? 0 : g - 1];

        always_comb begin
            w_ctl[g] = '0;
            // a rejected add leaves the cells untouched
            if ((r_state == cmrt_pkg::S_INSERT) && (n_res.status == cmrt_pkg::ST_OK)
                && (FW'(g) <= r_fill)) begin
                if (!prev_le) begin
                    w_ctl[g].shift = 1'b1;
                end else if (!w_le[g]) begin
                    w_ctl[g].load_new = 1'b1;
                end
            end
            if ((r_state == cmrt_pkg::S_SEARCH) && (r_lo < r_hi)
                && (r_req.address != '0)
                && (w_mid[IW-1:0] == IW'(g))
                && (r_req.address >= w_sel.base) && (r_req.address < w_sel.end_addr)
                && (w_sel.stride == '0)) begin
                w_ctl[g].set_live = 1'b1;
            end
            if (w_mark_hit && (r_mid == IW'(g))) begin
                w_ctl[g].set_mark = 1'b1;
                w_ctl[g].mark_bit = w_mark_bit;
            end
        end

        cmrt_cell u_cell (
            .i_clk     (i_clk),
            .i_prev    ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g - 1]),
            .i_new     (w_new),
            .i_ctl     (w_ctl[g]),
            .i_key     (r_req.address),
            .o_entry   (w_entry[g]),
            .o_base_le (w_le_raw[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmrt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (cmrt_pkg::t_mode'(i_in_req.mode))
                        cmrt_pkg::MODE_ADD: begin
                            if (i_in_req.length == '0 || r_fill >= FW'(MAX_BLOCKS)
                                || i_in_req.stride_bytes == '0) begin
                                n_state = cmrt_pkg::S_INSERT;
                            end else begin
                                n_state = cmrt_pkg::S_ADD_DIV;
                            end
                        end
                        cmrt_pkg::MODE_MARK:  n_state = cmrt_pkg::S_SEARCH;
                        default:              n_state = cmrt_pkg::S_DONE;
                    endcase
                end
            end
            cmrt_pkg::S_ADD_DIV: begin
                if (w_div_done) begin
                    n_state = cmrt_pkg::S_INSERT;
                end
            end
            cmrt_pkg::S_INSERT: n_state = cmrt_pkg::S_DONE;
            cmrt_pkg::S_SEARCH: begin
                if (r_req.address == '0 || r_lo >= r_hi) begin
                    n_state = cmrt_pkg::S_DONE;
                end else if (r_req.address >= w_sel.base
                             && r_req.address < w_sel.end_addr) begin
                    if (w_sel.stride == '0) begin
                        n_state = cmrt_pkg::S_DONE;
                    end else begin
                        n_state = cmrt_pkg::S_MARK_DIV;
                    end
                end
            end
            cmrt_pkg::S_MARK_DIV: begin
                if (w_div_done) begin
                    n_state = cmrt_pkg::S_DONE;
                end
            end
            cmrt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = cmrt_pkg::S_IDLE;
                end
            end
            default: n_state = cmrt_pkg::S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_res   = r_res;
        n_fill  = r_fill;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_slots = r_slots;
        unique case (r_state)
            cmrt_pkg::S_IDLE: begin
                n_res   = '0;
                n_lo    = '0;
                n_hi    = r_fill;
                n_slots = '0;
                if (i_in_valid) begin
                    if (cmrt_pkg::t_mode'(i_in_req.mode) == cmrt_pkg::MODE_CLEAR) begin
                        n_fill = '0;
                    end
                    if (cmrt_pkg::t_mode'(i_in_req.mode) == cmrt_pkg::MODE_MARK) begin
                        n_res.status = cmrt_pkg::ST_NO_BLOCK;
                    end
                end
            end
            cmrt_pkg::S_ADD_DIV: begin
                if (w_div_done) begin
                    n_slots = w_div_q[6:0];
                    if (w_div_q > 32'(SLOTS_PER_BLOCK)) begin
                        n_res.status = cmrt_pkg::ST_REJECT;
                    end
                end
            end
            cmrt_pkg::S_INSERT: begin
                if (r_res.status == cmrt_pkg::ST_OK) begin
                    if (r_req.length == '0 || r_fill >= FW'(MAX_BLOCKS) || w_end[64]) begin
                        n_res.status = cmrt_pkg::ST_REJECT;
                    end
                end
            end
            cmrt_pkg::S_SEARCH: begin
                n_mid = w_mid[IW-1:0];
                if (r_req.address != '0 && r_lo < r_hi) begin
                    if (r_req.address < w_sel.base) begin
                        n_hi = w_mid;
                    end else if (r_req.address >= w_sel.end_addr) begin
                        n_lo = FW'(w_mid + 1'b1);
                    end else begin
                        n_res.status = cmrt_pkg::ST_OK;
                    end
                end
            end
            cmrt_pkg::S_MARK_DIV: begin
                if (w_div_done) begin
                    if (w_div_r != '0) begin
                        n_res.status = cmrt_pkg::ST_MISALIGNED;
                    end else if (w_div_q >= {25'd0, w_entry[r_mid].slots}) begin
                        n_res.status = cmrt_pkg::ST_SLOT_RANGE;
                    end
                end
            end
            cmrt_pkg::S_DONE: ;
            default: ;
        endcase
        // add commits one entry when not rejected
        if (r_state == cmrt_pkg::S_INSERT && n_res.status == cmrt_pkg::ST_OK) begin
            n_fill = FW'(r_fill + 1'b1);
        end
    end

    // response assembly with the sweep lookup
    always_comb begin
        w_out             = r_res;
        w_out.entry_total = 6'(r_fill);
        if (cmrt_pkg::t_mode'(r_req.mode) == cmrt_pkg::MODE_SWEEP) begin
            if (32'(r_req.entry_index) >= 32'(r_fill)) begin
                w_out.status = cmrt_pkg::ST_BAD_INDEX;
            end else begin
                w_out.status       = cmrt_pkg::ST_OK;
                w_out.block_dead   = (w_entry[w_idx].stride == '0)
                                     ? !w_entry[w_idx].live
                                     : (w_entry[w_idx].marks == '0);
                w_out.live_mask    = w_entry[w_idx].marks;
                w_out.entry_base   = w_entry[w_idx].base;
                w_out.entry_stride = w_entry[w_idx].stride;
                w_out.entry_slots  = w_entry[w_idx].slots;
            end
        end
    end

    // state, request hold and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmrt_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (r_state == cmrt_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_state == cmrt_pkg::S_IDLE && i_in_valid) begin
            r_req <= i_in_req;
        end
        r_res   <= n_res;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_slots <= n_slots;
        if (r_state == cmrt_pkg::S_DONE && w_out_free) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
endmodule
`default_nettype wire

// ===== hdl/cmrt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// depends on cmrt_pkg
module cmrt_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot,
    output logic [15:0]      o_rem
);
    localparam int CW = $clog2(cmrt_pkg::DivSteps);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_q, n_q;
    logic [15:0]   r_r, n_r;
    logic [15:0]   r_d, n_d;
    logic          r_done, n_done;
    logic [16:0]   w_trial;

    // one quotient bit per step
    always_comb begin
        w_trial = {r_r, r_q[31]};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_r     = r_r;
        n_d     = r_d;
        n_done  = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_r    = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_d}) begin
                n_r = 16'(w_trial - {1'b0, r_d});
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = w_trial[15:0];
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = CW'(r_cnt + 1'b1);
            if (r_cnt == CW'(cmrt_pkg::DivSteps - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ===== hdl/cmrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one table entry: takes its left neighbor on insert shift, or the new block
// depends on cmrt_pkg
module cmrt_cell (
    input  wire logic                 i_clk,
    input  wire cmrt_pkg::t_entry     i_prev,
    input  wire cmrt_pkg::t_entry     i_new,
    input  wire cmrt_pkg::t_cell_ctl  i_ctl,
    input  wire logic [63:0]          i_key,
    output cmrt_pkg::t_entry          o_entry,
    output logic                      o_base_le
);
    cmrt_pkg::t_entry r_e, n_e;

    // entry update
    always_comb begin
        n_e = r_e;
        if (i_ctl.shift) begin
            n_e = i_prev;
        end else if (i_ctl.load_new) begin
            n_e = i_new;
        end else begin
            if (i_ctl.set_live) begin
                n_e.live = 1'b1;
            end
            if (i_ctl.set_mark) begin
                n_e.marks = r_e.marks | (64'd1 << i_ctl.mark_bit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_entry   = r_e;
    assign o_base_le = (r_e.base <= i_key);
endmodule
`default_nettype wire

// ===== tb/cmrt_checker.sv =====
`timescale 1ns / 1ps
// checker for the conservative mark range table: predicts each response
// from the accepted requests and compares it with the block's output
// depends on cmrt_pkg
module cmrt_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_stall,
    input  wire cmrt_pkg::t_req i_in_req,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_stall,
    input  wire cmrt_pkg::t_rsp i_out_rsp,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    import cmrt_pkg::*;

    localparam int NumBlocks = MaxBlocksDef;
    localparam int NumSlots  = SlotsPerBlockDef;

    // shadow copy of the block table
    logic [63:0] shd_base  [NumBlocks];
    logic [63:0] shd_end   [NumBlocks];
    logic [15:0] shd_stride[NumBlocks];
    logic [6:0]  shd_slots [NumBlocks];
    logic [63:0] shd_marks [NumBlocks];
    logic        shd_live  [NumBlocks];
    int          shd_fill;

    t_rsp rsp_expected_q[$];

    // insert a block in base order, after any entries with the same base
    function automatic t_status insert_block(logic [63:0] base, logic [31:0] len,
                                             logic [15:0] stride);
        logic [64:0] extent;
        logic [31:0] nslots;
        int          pos;
        extent = {1'b0, base} + {33'd0, len};
        nslots = 0;
        pos    = 0;
        if (len == 0 || shd_fill >= NumBlocks) return ST_REJECT;
        if (extent[64]) return ST_REJECT;
        if (stride != 0) nslots = len / {16'd0, stride};
        if (nslots > NumSlots) return ST_REJECT;
        while (pos < shd_fill && shd_base[pos] <= base) pos++;
        for (int i = shd_fill; i > pos; i--) begin
            shd_base[i]   = shd_base[i-1];
            shd_end[i]    = shd_end[i-1];
            shd_stride[i] = shd_stride[i-1];
            shd_slots[i]  = shd_slots[i-1];
            shd_marks[i]  = shd_marks[i-1];
            shd_live[i]   = shd_live[i-1];
        end
        shd_base[pos]   = base;
        shd_end[pos]    = extent[63:0];
        shd_stride[pos] = stride;
        shd_slots[pos]  = nslots[6:0];
        shd_marks[pos]  = '0;
        shd_live[pos]   = 1'b0;
        shd_fill++;
        return ST_OK;
    endfunction

    // binary search for the containing block and set its mark
    function automatic t_status mark_pointer(logic [63:0] ptr);
        int          lo;
        int          hi;
        int          mid;
        logic [63:0] off;
        logic [63:0] slot;
        lo = 0;
        hi = shd_fill;
        if (ptr == 0 || shd_fill == 0) return ST_NO_BLOCK;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (ptr < shd_base[mid]) begin
                hi = mid;
            end else if (ptr >= shd_end[mid]) begin
                lo = mid + 1;
            end else begin
                off = ptr - shd_base[mid];
                if (shd_stride[mid] == 0) begin
                    shd_live[mid] = 1'b1;
                    return ST_OK;
                end
                if (off % {48'd0, shd_stride[mid]} != 0) return ST_MISALIGNED;
                slot = off / {48'd0, shd_stride[mid]};
                if (slot >= {57'd0, shd_slots[mid]}) return ST_SLOT_RANGE;
                shd_marks[mid] |= 64'd1 << slot[5:0];
                return ST_OK;
            end
        end
        return ST_NO_BLOCK;
    endfunction

    function automatic t_rsp table_response(t_req rq);
        t_rsp rsp;
        int   idx;
        rsp = '0;
        idx = rq.entry_index;
        case (t_mode'(rq.mode))
            MODE_CLEAR: begin
                shd_fill   = 0;
                rsp.status = ST_OK;
            end
            MODE_ADD:  rsp.status = insert_block(rq.address, rq.length, rq.stride_bytes);
            MODE_MARK: rsp.status = mark_pointer(rq.address);
            default: begin
                if (idx >= shd_fill) begin
                    rsp.status = ST_BAD_INDEX;
                end else begin
                    rsp.status       = ST_OK;
                    rsp.block_dead   = (shd_stride[idx] == 0) ? !shd_live[idx]
                                                              : (shd_marks[idx] == 0);
                    rsp.live_mask    = shd_marks[idx];
                    rsp.entry_base   = shd_base[idx];
                    rsp.entry_stride = shd_stride[idx];
                    rsp.entry_slots  = shd_slots[idx];
                end
            end
        endcase
        rsp.entry_total = shd_fill[5:0];
        return rsp;
    endfunction

    function automatic int field_diff(string fname, logic [63:0] want, logic [63:0] got);
        if (want === got) return 0;
        $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
        return 1;
    endfunction

    // track requests and compare responses
    always @(posedge i_clk) begin
        t_rsp want;
        int   bad;
        if (!i_rst_n) begin
            shd_fill     = 0;
            o_fail_count = 0;
            o_checked    = 0;
            for (int i = 0; i < NumBlocks; i++) begin
                shd_marks[i] = '0;
                shd_live[i]  = 1'b0;
            end
            rsp_expected_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) rsp_expected_q.push_back(table_response(i_in_req));
            if (i_out_valid && !i_out_stall) begin
                if (rsp_expected_q.size() == 0) begin
                    $display("%0t: response with no request waiting, actual %0h",
                             $time, i_out_rsp);
                    o_fail_count++;
                end else begin
                    want = rsp_expected_q.pop_front();
                    bad  = field_diff("status", want.status, i_out_rsp.status)
                         + field_diff("entry_total", want.entry_total, i_out_rsp.entry_total)
                         + field_diff("block_dead", want.block_dead, i_out_rsp.block_dead)
                         + field_diff("live_mask", want.live_mask, i_out_rsp.live_mask)
                         + field_diff("entry_base", want.entry_base, i_out_rsp.entry_base)
                         + field_diff("entry_stride", want.entry_stride,
                                      i_out_rsp.entry_stride)
                         + field_diff("entry_slots", want.entry_slots, i_out_rsp.entry_slots);
                    if (bad != 0) o_fail_count++;
                    o_checked++;
                end
            end
        end
        o_pending = rsp_expected_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the conservative mark range table testbench: clock, reset, request
// stimulus, response stalls and verdict; depends on cmrt_pkg, cmrt_checker
// and conservative_mark_range_table_top
module testbench;
    import cmrt_pkg::*;

    localparam int WatchLimit = 20000;
    localparam int RandCount  = 1700;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    t_req i_in_req = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out_rsp;
    int   fail_count;
    int   pending;
    int   checked;
    logic calm = 1'b0;
    int   idle_cycles = 0;
    int   reqs_sent = 0;

    // blocks the stimulus has tried to add, used to aim marks
    logic [63:0] aim_base[$];
    logic [31:0] aim_len[$];
    logic [15:0] aim_stride[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    conservative_mark_range_table_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_rsp(o_out_rsp)
    );

    cmrt_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_req(i_in_req),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_rsp(o_out_rsp),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // random response stalls
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 32);
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WatchLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic issue_req(input t_req rq);
        if (!calm && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= rq;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        reqs_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue_fields(input t_mode md, input logic [63:0] addr,
                                input logic [31:0] len, input logic [15:0] stride,
                                input logic [4:0] idx);
        t_req rq;
        rq.mode         = md;
        rq.address      = addr;
        rq.length       = len;
        rq.stride_bytes = stride;
        rq.entry_index  = idx;
        if (md == MODE_CLEAR) begin
            aim_base.delete();
            aim_len.delete();
            aim_stride.delete();
        end
        if (md == MODE_ADD && len != 0) begin
            aim_base.push_back(addr);
            aim_len.push_back(len);
            aim_stride.push_back(stride);
            if (aim_base.size() > 40) begin
                void'(aim_base.pop_front());
                void'(aim_len.pop_front());
                void'(aim_stride.pop_front());
            end
        end
        issue_req(rq);
    endtask

    // well-formed add with random geometry
    task automatic add_plausible();
        logic [63:0] base;
        logic [15:0] stride;
        logic [31:0] len;
        int          nslots;
        base   = 64'($urandom_range(1, 60)) << 12;
        if ($urandom_range(9) == 0) base[63:32] = $urandom;
        stride = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(1, 16) * 8);
        nslots = $urandom_range(0, 66);
        if (stride == 0) len = $urandom_range(1, 4096);
        else len = stride * nslots + $urandom_range(0, stride - 1);
        if (len == 0) len = stride;
        issue_fields(MODE_ADD, base, len, stride, 5'($urandom));
    endtask

    // mark aimed at a known block, mostly aligned
    task automatic mark_plausible();
        int          k;
        logic [63:0] ptr;
        if (aim_base.size() == 0) begin
            ptr = 64'($urandom_range(0, 65535));
        end else begin
            k = $urandom_range(0, aim_base.size() - 1);
            if (aim_stride[k] == 0) begin
                ptr = aim_base[k] + $urandom_range(0, aim_len[k] - 1);
            end else begin
                ptr = aim_base[k] + aim_stride[k] * $urandom_range(0, 66);
                if ($urandom_range(99) < 15) ptr = ptr + $urandom_range(1, 7);
            end
        end
        issue_fields(MODE_MARK, ptr, $urandom, 16'($urandom), 5'($urandom));
    endtask

    initial begin
        t_req rq;
        int   r;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, rejects, geometry corners, mark outcomes
        issue_fields(MODE_CLEAR, 64'd0, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h1000, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_SWEEP, 64'd0, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_ADD, 64'h5000, 32'd0, 16'd8, 5'd0);
        issue_fields(MODE_ADD, 64'hFFFF_FFFF_FFFF_FF00, 32'h200, 16'd8, 5'd0);
        issue_fields(MODE_ADD, 64'd0, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F);
        issue_fields(MODE_ADD, 64'h1000, 32'd520, 16'd8, 5'd0);
        issue_fields(MODE_ADD, 64'h1000, 32'd512, 16'd8, 5'd0);
        issue_fields(MODE_ADD, 64'h3000, 32'd16, 16'd32, 5'd0);
        issue_fields(MODE_ADD, 64'h2000, 32'h100, 16'd0, 5'd0);
        issue_fields(MODE_ADD, 64'h1000, 32'h40, 16'd16, 5'd0);
        issue_fields(MODE_MARK, 64'd0, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h1000, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h1008, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h1001, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h2080, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h3000, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h3004, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'h9000, 32'd0, 16'd0, 5'd0);
        issue_fields(MODE_MARK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 16'd0, 5'd0);
        for (int i = 0; i < 4; i++) issue_fields(MODE_SWEEP, 64'd0, 32'd0, 16'd0, 5'(i));
        issue_fields(MODE_SWEEP, 64'd0, 32'd0, 16'd0, 5'h1F);
        // fill the table to the top, then one add too many
        for (int i = 0; i < 29; i++)
            issue_fields(MODE_ADD, 64'h8000 - 64'(i * 'h100), 32'h80, 16'd16, 5'd0);
        issue_fields(MODE_SWEEP, 64'd0, 32'd0, 16'd0, 5'h1F);

        // random: mostly well-formed traffic with some raw noise
        for (int n = 0; n < RandCount; n++) begin
            calm = (n >= 700 && n < 950);
            r = $urandom_range(99);
            if (r < 3) begin
                issue_fields(MODE_CLEAR, {$urandom, $urandom}, $urandom, 16'($urandom),
                             5'($urandom));
            end else if (r < 30) begin
                add_plausible();
            end else if (r < 68) begin
                mark_plausible();
            end else if (r < 88) begin
                issue_fields(MODE_SWEEP, {$urandom, $urandom}, $urandom, 16'($urandom),
                             5'($urandom_range(0, aim_base.size() > 31 ? 31 :
                                              (aim_base.size() == 0 ? 0 : aim_base.size()))));
            end else begin
                rq.mode         = 2'($urandom_range(1, 3));
                rq.address      = {$urandom, $urandom};
                rq.length       = $urandom;
                rq.stride_bytes = 16'($urandom);
                rq.entry_index  = 5'($urandom);
                issue_fields(t_mode'(rq.mode), rq.address, rq.length, rq.stride_bytes,
                             rq.entry_index);
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // drain and let the block settle
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("run covered %0d requests, %0d responses compared", reqs_sent, checked);
        $display("clear, add, mark and sweep requests with random stalls on both channels");
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
